FILE: src/dcf77_pulse_and_frame_decoder_assert.svh
// assertion helpers shared by the decoder modules
`ifndef DCF77_PULSE_AND_FRAME_DECODER_ASSERT_SVH
`define DCF77_PULSE_AND_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcf assertion failed");

// next-cycle implication, checked out of reset
`define DCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcf assertion failed");

`endif

FILE: src/dcf_pkg.sv
package dcf_pkg;

  // event codes
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ZERO = 3'd1;
  localparam logic [2:0] EV_ONE  = 3'd2;
  localparam logic [2:0] EV_SEC  = 3'd3;
  localparam logic [2:0] EV_MIN  = 3'd4;
  localparam logic [2:0] EV_INV  = 3'd5;

  // pulse timing windows in ms
  localparam int unsigned ZERO_LO    = 70;
  localparam int unsigned ZERO_HI    = 130;
  localparam int unsigned ONE_LO     = 170;
  localparam int unsigned ONE_HI     = 230;
  localparam int unsigned SEC_LO     = 900;
  localparam int unsigned SEC_HI     = 1100;
  localparam int unsigned MIN_LO     = 1900;
  localparam int unsigned MIN_HI     = 2100;
  localparam int unsigned SILENCE_MS = 3000;

  // frame positions
  localparam logic [5:0] SEC_START   = 6'd20;
  localparam logic [5:0] SEC_MPAR    = 6'd28;
  localparam logic [5:0] SEC_MIN_END = 6'd27;
  localparam logic [5:0] SEC_HR_END  = 6'd34;
  localparam logic [5:0] SEC_DAY_END = 6'd41;
  localparam logic [5:0] SEC_WD_END  = 6'd44;
  localparam logic [5:0] SEC_MON_END = 6'd49;
  localparam logic [5:0] SEC_LAST    = 6'd63;
  localparam logic [6:0] MINUTE_MAX  = 7'd59;

  localparam int unsigned EVQ_DEPTH = 2;
  localparam int unsigned EVQ_AW    = $clog2(EVQ_DEPTH);

  typedef struct packed {
    logic        signal_level;
    logic [15:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       time_update;
    logic       sync_error;
    logic [6:0] out_minute;
    logic [5:0] out_hour;
    logic [5:0] out_day;
    logic [2:0] out_weekday;
    logic [4:0] out_month;
    logic [7:0] out_year;
  } out_item_t;

  // front to queue
  typedef struct packed {
    logic       push;
    logic [2:0] ev;
  } evq_wr_t;

  // queue to back
  typedef struct packed {
    logic       valid;
    logic [2:0] ev;
  } evq_rd_t;

  // bcd weight of each second of the frame
  function automatic logic [6:0] bit_weight(input logic [5:0] s);
    logic [6:0] w;
    case (s)
      6'd21, 6'd29, 6'd36, 6'd42, 6'd45, 6'd50: w = 7'd1;
      6'd22, 6'd30, 6'd37, 6'd43, 6'd46, 6'd51: w = 7'd2;
      6'd23, 6'd31, 6'd38, 6'd44, 6'd47, 6'd52: w = 7'd4;
      6'd24, 6'd32, 6'd39, 6'd48, 6'd53:        w = 7'd8;
      6'd25, 6'd33, 6'd40, 6'd49, 6'd54:        w = 7'd10;
      6'd26, 6'd34, 6'd41, 6'd55:               w = 7'd20;
      6'd27, 6'd56:                             w = 7'd40;
      6'd57:                                    w = 7'd80;
      default:                                  w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: src/dcf77_pulse_and_frame_decoder.sv
// channel | dir | handshake            | beat payload
// in_     | in  | in_valid / in_stall   | signal_level, time_ms
// out_    | out | out_valid / out_stall | event, update, sync, published time and date
//
// one beat in and one result beat out per cycle sustained while out_stall is low; a taken beat
// passes through the event queue into the output register, held there until out_stall is low
// the front classifies edges in the accept cycle, a two-entry event queue decouples it
// from the frame decoder, so in_stall rises only when that queue is full
// rst_n (synchronous) clears edge timing, sync, accumulators and published time to zero
module dcf77_pulse_and_frame_decoder #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dcf_pkg::out_item_t out_item
);

  dcf_pkg::evq_wr_t evq_wr;
  dcf_pkg::evq_rd_t evq_rd;
  logic             evq_full;
  logic             evq_pop;

  dcf_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .evq_full (evq_full),
    .evq_wr   (evq_wr)
  );

  dcf_evq u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (evq_wr),
    .full  (evq_full),
    .pop   (evq_pop),
    .rd    (evq_rd)
  );

  dcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evq_rd    (evq_rd),
    .evq_pop   (evq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: src/dcf_front.sv
module dcf_front #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcf_pkg::in_item_t  in_item,
  input  logic               evq_full,
  output dcf_pkg::evq_wr_t   evq_wr
);

  logic                  prev_level_r, prev_level_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r, last_edge_nxt;
  logic [TIME_WIDTH-1:0] last_fall_r, last_fall_nxt;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] d_fall;
  logic [TIME_WIDTH-1:0] d_edge;
  logic [2:0]            ev;
  logic                  accept;

  assign in_stall = evq_full;
  assign accept   = in_valid && !in_stall;
  assign now      = TIME_WIDTH'(in_item.time_ms);
  assign d_fall   = now - last_fall_r;
  assign d_edge   = now - last_edge_r;

  always_comb begin
    ev             = dcf_pkg::EV_NONE;
    prev_level_nxt = prev_level_r;
    last_edge_nxt  = last_edge_r;
    last_fall_nxt  = last_fall_r;
    if (in_item.signal_level != prev_level_r) begin
      if (!prev_level_r) begin
        // rising edge: low time decides the bit
        if (d_fall >= TIME_WIDTH'(dcf_pkg::ZERO_LO) && d_fall <= TIME_WIDTH'(dcf_pkg::ZERO_HI))
          ev = dcf_pkg::EV_ZERO;
        else if (d_fall >= TIME_WIDTH'(dcf_pkg::ONE_LO) && d_fall <= TIME_WIDTH'(dcf_pkg::ONE_HI))
          ev = dcf_pkg::EV_ONE;
        else
          ev = dcf_pkg::EV_INV;
      end else begin
        // falling edge: period since the previous falling edge
        if (d_fall >= TIME_WIDTH'(dcf_pkg::SEC_LO) && d_fall <= TIME_WIDTH'(dcf_pkg::SEC_HI))
          ev = dcf_pkg::EV_SEC;
        else if (d_fall >= TIME_WIDTH'(dcf_pkg::MIN_LO) && d_fall <= TIME_WIDTH'(dcf_pkg::MIN_HI))
          ev = dcf_pkg::EV_MIN;
        else
          ev = dcf_pkg::EV_INV;
        last_fall_nxt = now;
      end
      prev_level_nxt = in_item.signal_level;
      last_edge_nxt  = now;
    end else if (d_edge > TIME_WIDTH'(dcf_pkg::SILENCE_MS)) begin
      ev            = dcf_pkg::EV_INV;
      last_edge_nxt = now;
    end
  end

  assign evq_wr.push = accept;
  assign evq_wr.ev   = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      last_edge_r  <= '0;
      last_fall_r  <= '0;
    end else if (accept) begin
      prev_level_r <= prev_level_nxt;
      last_edge_r  <= last_edge_nxt;
      last_fall_r  <= last_fall_nxt;
    end
  end

endmodule

FILE: src/dcf_evq.sv
`include "dcf77_pulse_and_frame_decoder_assert.svh"

module dcf_evq (
  input  logic             clk,
  input  logic             rst_n,
  input  dcf_pkg::evq_wr_t wr,
  output logic             full,
  input  logic             pop,
  output dcf_pkg::evq_rd_t rd
);

  localparam int unsigned AW = dcf_pkg::EVQ_AW;

  logic [2:0]    mem_r [dcf_pkg::EVQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(dcf_pkg::EVQ_DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.ev    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr.push)
      wr_ptr_nxt = (wr_ptr_r == AW'(dcf_pkg::EVQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == AW'(dcf_pkg::EVQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + (AW+1)'(wr.push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr.push)
      mem_r[wr_ptr_r] <= wr.ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DCF_ASSERT_NOW(a_evq_no_overflow, clk, rst_n, wr.push, !full || pop)
  `DCF_ASSERT_NOW(a_evq_no_underflow, clk, rst_n, pop, rd.valid)
  `DCF_ASSERT_NOW(a_evq_count_bound, clk, rst_n, 1'b1, count_r <= (AW+1)'(dcf_pkg::EVQ_DEPTH))

endmodule

FILE: src/dcf_back.sv
`include "dcf77_pulse_and_frame_decoder_assert.svh"

module dcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dcf_pkg::evq_rd_t   evq_rd,
  output logic               evq_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dcf_pkg::out_item_t out_item
);

  logic       out_valid_r;
  logic [2:0] ev_r, ev_nxt;
  logic       upd_r, upd_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic       in_sync_r, in_sync_nxt;
  logic       parity_r, parity_nxt;
  logic [6:0] minute_r, minute_nxt;
  logic [5:0] hour_r, hour_nxt;
  logic [5:0] day_r, day_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [4:0] month_r, month_nxt;
  logic [7:0] year_r, year_nxt;
  logic [6:0] pub_minute_r, pub_minute_nxt;
  logic [5:0] pub_hour_r, pub_hour_nxt;
  logic [5:0] pub_day_r, pub_day_nxt;
  logic [2:0] pub_wday_r, pub_wday_nxt;
  logic [4:0] pub_month_r, pub_month_nxt;
  logic [7:0] pub_year_r, pub_year_nxt;
  logic [6:0] w;
  logic       one;

  // the result register is free or being emptied this cycle
  assign evq_pop = evq_rd.valid && (!out_valid_r || !out_stall);
  assign w       = dcf_pkg::bit_weight(sec_r);
  assign one     = (evq_rd.ev == dcf_pkg::EV_ONE);

  always_comb begin
    ev_nxt         = ev_r;
    upd_nxt        = upd_r;
    sec_nxt        = sec_r;
    in_sync_nxt    = in_sync_r;
    parity_nxt     = parity_r;
    minute_nxt     = minute_r;
    hour_nxt       = hour_r;
    day_nxt        = day_r;
    wday_nxt       = wday_r;
    month_nxt      = month_r;
    year_nxt       = year_r;
    pub_minute_nxt = pub_minute_r;
    pub_hour_nxt   = pub_hour_r;
    pub_day_nxt    = pub_day_r;
    pub_wday_nxt   = pub_wday_r;
    pub_month_nxt  = pub_month_r;
    pub_year_nxt   = pub_year_r;
    if (evq_pop) begin
      ev_nxt  = evq_rd.ev;
      upd_nxt = 1'b0;
      if (evq_rd.ev == dcf_pkg::EV_MIN) begin
        if (in_sync_r && sec_r != '0) begin
          pub_minute_nxt = minute_r;
          pub_hour_nxt   = hour_r;
          pub_day_nxt    = day_r;
          pub_wday_nxt   = wday_r;
          pub_month_nxt  = month_r;
          pub_year_nxt   = year_r;
          upd_nxt        = 1'b1;
        end
        in_sync_nxt = 1'b1;
        sec_nxt     = '0;
      end else if (in_sync_r) begin
        case (evq_rd.ev)
          dcf_pkg::EV_SEC: begin
            if (sec_r != dcf_pkg::SEC_LAST)
              sec_nxt = sec_r + 6'd1;
          end
          dcf_pkg::EV_INV: begin
            in_sync_nxt = 1'b0;
          end
          dcf_pkg::EV_ZERO, dcf_pkg::EV_ONE: begin
            if (sec_r == dcf_pkg::SEC_START) begin
              // start-of-time bit must be 1; fresh frame fields, all but the hour
              if (!one)
                in_sync_nxt = 1'b0;
              parity_nxt = 1'b0;
              minute_nxt = '0;
              day_nxt    = '0;
              wday_nxt   = '0;
              month_nxt  = '0;
              year_nxt   = '0;
            end else if (sec_r == dcf_pkg::SEC_MPAR) begin
              if (one != parity_r || minute_r > dcf_pkg::MINUTE_MAX)
                in_sync_nxt = 1'b0;
              parity_nxt = 1'b0;
              hour_nxt   = '0;
            end else if (one && w != '0) begin
              parity_nxt = !parity_r;
              if (sec_r <= dcf_pkg::SEC_MIN_END)
                minute_nxt = minute_r + w;
              else if (sec_r <= dcf_pkg::SEC_HR_END)
                hour_nxt = hour_r + w[5:0];
              else if (sec_r <= dcf_pkg::SEC_DAY_END)
                day_nxt = day_r + w[5:0];
              else if (sec_r <= dcf_pkg::SEC_WD_END)
                wday_nxt = wday_r + w[2:0];
              else if (sec_r <= dcf_pkg::SEC_MON_END)
                month_nxt = month_r + w[4:0];
              else
                year_nxt = year_r + {1'b0, w};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      ev_r         <= dcf_pkg::EV_NONE;
      upd_r        <= 1'b0;
      sec_r        <= '0;
      in_sync_r    <= 1'b0;
      parity_r     <= 1'b0;
      minute_r     <= '0;
      hour_r       <= '0;
      day_r        <= '0;
      wday_r       <= '0;
      month_r      <= '0;
      year_r       <= '0;
      pub_minute_r <= '0;
      pub_hour_r   <= '0;
      pub_day_r    <= '0;
      pub_wday_r   <= '0;
      pub_month_r  <= '0;
      pub_year_r   <= '0;
    end else begin
      if (evq_pop)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
      ev_r         <= ev_nxt;
      upd_r        <= upd_nxt;
      sec_r        <= sec_nxt;
      in_sync_r    <= in_sync_nxt;
      parity_r     <= parity_nxt;
      minute_r     <= minute_nxt;
      hour_r       <= hour_nxt;
      day_r        <= day_nxt;
      wday_r       <= wday_nxt;
      month_r      <= month_nxt;
      year_r       <= year_nxt;
      pub_minute_r <= pub_minute_nxt;
      pub_hour_r   <= pub_hour_nxt;
      pub_day_r    <= pub_day_nxt;
      pub_wday_r   <= pub_wday_nxt;
      pub_month_r  <= pub_month_nxt;
      pub_year_r   <= pub_year_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item.event_res   = ev_r;
  assign out_item.time_update = upd_r;
  assign out_item.sync_error  = !in_sync_r;
  assign out_item.out_minute  = pub_minute_r;
  assign out_item.out_hour    = pub_hour_r;
  assign out_item.out_day     = pub_day_r;
  assign out_item.out_weekday = pub_wday_r;
  assign out_item.out_month   = pub_month_r;
  assign out_item.out_year    = pub_year_r;

  `DCF_ASSERT_NOW(a_upd_only_on_marker, clk, rst_n, out_valid && out_item.time_update, out_item.event_res == dcf_pkg::EV_MIN && !out_item.sync_error)
  `DCF_ASSERT_NOW(a_invalid_drops_sync, clk, rst_n, out_valid && out_item.event_res == dcf_pkg::EV_INV, out_item.sync_error)
  `DCF_ASSERT_NEXT(a_pub_held, clk, rst_n, evq_pop && evq_rd.ev != dcf_pkg::EV_MIN, $stable(pub_minute_r) && $stable(pub_year_r))

endmodule

FILE: dv/tb_dcf77_pulse_and_frame_decoder.sv
module tb_dcf77_pulse_and_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_TICKS = 1360;
  localparam int unsigned CYCLE_LIMIT  = 600_000;
  localparam int unsigned LONG_HOLD    = 300;

  typedef enum {
    FLAW_NONE, FLAW_NO_START, FLAW_PARITY, FLAW_BIG_MINUTE,
    FLAW_PULSE, FLAW_GAP, FLAW_LONG, FLAW_SHORT
  } frame_flaw_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               out_stall = 1'b0;
  dcf_pkg::in_item_t  in_item   = '0;
  logic               in_stall;
  logic               out_valid;
  dcf_pkg::out_item_t out_item;

  dcf77_pulse_and_frame_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  dcf_pkg::in_item_t  tick_q[$];
  dcf_pkg::out_item_t decoded_q[$];
  int unsigned n_total      = 0;
  int unsigned n_taken      = 0;
  int unsigned beat_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle      = 0;
  int unsigned rx_hold      = 0;
  int unsigned long_holds   = 0;

  // decoder state mirror
  logic        fr_level  = 1'b0;
  logic [15:0] fr_edge_t = '0;
  logic [15:0] fr_fall_t = '0;
  logic [5:0]  fr_sec    = '0;
  logic        fr_sync   = 1'b0;
  logic        fr_par    = 1'b0;
  logic [6:0]  fr_min    = '0;
  logic [5:0]  fr_hour   = '0;
  logic [5:0]  fr_day    = '0;
  logic [2:0]  fr_wday   = '0;
  logic [4:0]  fr_mon    = '0;
  logic [7:0]  fr_year   = '0;
  logic [6:0]  pub_min   = '0;
  logic [5:0]  pub_hour  = '0;
  logic [5:0]  pub_day   = '0;
  logic [2:0]  pub_wday  = '0;
  logic [4:0]  pub_mon   = '0;
  logic [7:0]  pub_year  = '0;

  // stimulus generator's view of the line
  logic        gen_lvl  = 1'b0;
  logic [15:0] gen_fall = '0;
  logic [15:0] gen_t    = '0;

  function automatic logic [6:0] digit_weight(input int unsigned k);
    case (k)
      0:       return 7'd1;
      1:       return 7'd2;
      2:       return 7'd4;
      3:       return 7'd8;
      4:       return 7'd10;
      5:       return 7'd20;
      6:       return 7'd40;
      default: return 7'd80;
    endcase
  endfunction

  function automatic logic [6:0] frame_weight(input logic [5:0] s);
    if (s > dcf_pkg::SEC_START && s <= dcf_pkg::SEC_MIN_END)
      return digit_weight(s - dcf_pkg::SEC_START - 1);
    if (s > dcf_pkg::SEC_MPAR && s <= dcf_pkg::SEC_HR_END)
      return digit_weight(s - dcf_pkg::SEC_MPAR - 1);
    // one parity second sits between hour and day
    if (s > dcf_pkg::SEC_HR_END + 1 && s <= dcf_pkg::SEC_DAY_END)
      return digit_weight(s - dcf_pkg::SEC_HR_END - 2);
    if (s > dcf_pkg::SEC_DAY_END && s <= dcf_pkg::SEC_WD_END)
      return digit_weight(s - dcf_pkg::SEC_DAY_END - 1);
    if (s > dcf_pkg::SEC_WD_END && s <= dcf_pkg::SEC_MON_END)
      return digit_weight(s - dcf_pkg::SEC_WD_END - 1);
    if (s > dcf_pkg::SEC_MON_END && s <= dcf_pkg::SEC_MON_END + 8)
      return digit_weight(s - dcf_pkg::SEC_MON_END - 1);
    return 7'd0;
  endfunction

  task automatic take_bit(input logic one);
    logic [6:0] w;
    w = frame_weight(fr_sec);
    if (fr_sec == dcf_pkg::SEC_START) begin
      if (!one) fr_sync = 1'b0;
      fr_par  = 1'b0;
      fr_min  = '0;
      fr_day  = '0;
      fr_wday = '0;
      fr_mon  = '0;
      fr_year = '0;
    end else if (fr_sec == dcf_pkg::SEC_MPAR) begin
      if (one != fr_par || fr_min > dcf_pkg::MINUTE_MAX) fr_sync = 1'b0;
      fr_par  = 1'b0;
      fr_hour = '0;
    end else if (one && w != '0) begin
      fr_par = ~fr_par;
      if (fr_sec <= dcf_pkg::SEC_MIN_END) fr_min = fr_min + w;
      else if (fr_sec <= dcf_pkg::SEC_HR_END) fr_hour = fr_hour + w[5:0];
      else if (fr_sec <= dcf_pkg::SEC_DAY_END) fr_day = fr_day + w[5:0];
      else if (fr_sec <= dcf_pkg::SEC_WD_END) fr_wday = fr_wday + w[2:0];
      else if (fr_sec <= dcf_pkg::SEC_MON_END) fr_mon = fr_mon + w[4:0];
      else fr_year = fr_year + 8'(w);
    end
  endtask

  task automatic decode_tick(input dcf_pkg::in_item_t it, output dcf_pkg::out_item_t res);
    logic [2:0]  ev;
    logic [15:0] span;
    logic        upd;
    ev  = dcf_pkg::EV_NONE;
    upd = 1'b0;
    if (it.signal_level != fr_level) begin
      span = it.time_ms - fr_fall_t;
      if (!fr_level) begin
        if (span >= dcf_pkg::ZERO_LO && span <= dcf_pkg::ZERO_HI) ev = dcf_pkg::EV_ZERO;
        else if (span >= dcf_pkg::ONE_LO && span <= dcf_pkg::ONE_HI) ev = dcf_pkg::EV_ONE;
        else ev = dcf_pkg::EV_INV;
      end else begin
        if (span >= dcf_pkg::SEC_LO && span <= dcf_pkg::SEC_HI) ev = dcf_pkg::EV_SEC;
        else if (span >= dcf_pkg::MIN_LO && span <= dcf_pkg::MIN_HI) ev = dcf_pkg::EV_MIN;
        else ev = dcf_pkg::EV_INV;
        fr_fall_t = it.time_ms;
      end
      fr_level  = it.signal_level;
      fr_edge_t = it.time_ms;
    end else begin
      span = it.time_ms - fr_edge_t;
      if (span > dcf_pkg::SILENCE_MS) begin
        ev        = dcf_pkg::EV_INV;
        fr_edge_t = it.time_ms;
      end
    end

    if (ev == dcf_pkg::EV_MIN) begin
      if (fr_sync && fr_sec != '0) begin
        pub_min  = fr_min;
        pub_hour = fr_hour;
        pub_day  = fr_day;
        pub_wday = fr_wday;
        pub_mon  = fr_mon;
        pub_year = fr_year;
        upd      = 1'b1;
      end
      fr_sync = 1'b1;
      fr_sec  = '0;
    end else if (fr_sync) begin
      case (ev)
        dcf_pkg::EV_SEC:                  if (fr_sec != dcf_pkg::SEC_LAST) fr_sec = fr_sec + 6'd1;
        dcf_pkg::EV_INV:                  fr_sync = 1'b0;
        dcf_pkg::EV_ZERO, dcf_pkg::EV_ONE: take_bit(ev == dcf_pkg::EV_ONE);
        default: ;
      endcase
    end

    res.event_res   = ev;
    res.time_update = upd;
    res.sync_error  = ~fr_sync;
    res.out_minute  = pub_min;
    res.out_hour    = pub_hour;
    res.out_day     = pub_day;
    res.out_weekday = pub_wday;
    res.out_month   = pub_mon;
    res.out_year    = pub_year;
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("beat %0d %s got %0d want %0d", beat_cnt, name, got, want));
  endtask

  task automatic check_decoded(input dcf_pkg::out_item_t got);
    dcf_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch($sformatf("beat %0d arrived with nothing pending", beat_cnt));
    end else begin
      want = decoded_q.pop_front();
      cmp_field("event_res", got.event_res, want.event_res);
      cmp_field("time_update", got.time_update, want.time_update);
      cmp_field("sync_error", got.sync_error, want.sync_error);
      cmp_field("out_minute", got.out_minute, want.out_minute);
      cmp_field("out_hour", got.out_hour, want.out_hour);
      cmp_field("out_day", got.out_day, want.out_day);
      cmp_field("out_weekday", got.out_weekday, want.out_weekday);
      cmp_field("out_month", got.out_month, want.out_month);
      cmp_field("out_year", got.out_year, want.out_year);
    end
    beat_cnt++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly well inside the window, now and then right on its edges
  function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    int unsigned m;
    r = $urandom_range(0, 19);
    m = (hi - lo) / 4;
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo + m, hi - m);
  endfunction

  function automatic frame_flaw_t pick_flaw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return FLAW_NONE;
    if (r < 76) return FLAW_NO_START;
    if (r < 82) return FLAW_PARITY;
    if (r < 86) return FLAW_BIG_MINUTE;
    if (r < 90) return FLAW_PULSE;
    if (r < 94) return FLAW_GAP;
    if (r < 97) return FLAW_LONG;
    return FLAW_SHORT;
  endfunction

  task automatic push_tick(input logic lvl, input logic [15:0] t);
    dcf_pkg::in_item_t it;
    it.signal_level = lvl;
    it.time_ms      = t;
    tick_q.push_back(it);
    if (gen_lvl && !lvl) gen_fall = t;
    gen_lvl = lvl;
    gen_t   = t;
  endtask

  // one second of carrier: pulse of the given width, next fall after gap
  task automatic emit_second(input int unsigned width, input int unsigned gap);
    logic [15:0] f;
    f = gen_fall;
    if ($urandom_range(0, 9) == 0) push_tick(1'b0, 16'(f + $urandom_range(1, width - 1)));
    push_tick(1'b1, 16'(f + width));
    if ($urandom_range(0, 9) == 0)
      push_tick(1'b1, 16'(f + $urandom_range(width + 1, gap - 1)));
    push_tick(1'b0, 16'(f + gap));
  endtask

  task automatic emit_marker();
    if (!gen_lvl) push_tick(1'b1, 16'(gen_fall + pick_in(dcf_pkg::ONE_LO, dcf_pkg::ONE_HI)));
    push_tick(1'b0, 16'(gen_fall + pick_in(dcf_pkg::MIN_LO, dcf_pkg::MIN_HI)));
  endtask

  task automatic emit_frame();
    logic [71:0]  bits;
    frame_flaw_t  flaw;
    int unsigned  n_sec;
    int unsigned  bad_at;
    int unsigned  width;
    int unsigned  gap;
    int unsigned  v;
    bits[31:0]  = $urandom;
    bits[63:32] = $urandom;
    bits[71:64] = 8'($urandom);
    if ($urandom_range(0, 1)) begin
      v = $urandom_range(0, 59);
      bits[24:21] = 4'(v % 10);
      bits[27:25] = 3'(v / 10);
      v = $urandom_range(0, 23);
      bits[32:29] = 4'(v % 10);
      bits[34:33] = 2'(v / 10);
      v = $urandom_range(1, 31);
      bits[39:36] = 4'(v % 10);
      bits[41:40] = 2'(v / 10);
      bits[44:42] = 3'($urandom_range(1, 7));
      v = $urandom_range(1, 12);
      bits[48:45] = 4'(v % 10);
      bits[49]    = 1'(v / 10);
      v = $urandom_range(0, 99);
      bits[53:50] = 4'(v % 10);
      bits[57:54] = 4'(v / 10);
    end
    flaw = pick_flaw();
    bits[dcf_pkg::SEC_START] = (flaw != FLAW_NO_START);
    if (flaw == FLAW_BIG_MINUTE) bits[27:25] = 3'b110 | 3'($urandom_range(0, 1));
    bits[dcf_pkg::SEC_MPAR] = ^bits[27:21];
    bits[35]                = ^bits[34:29];
    bits[58]                = ^bits[57:36];
    if (flaw == FLAW_PARITY) bits[dcf_pkg::SEC_MPAR] = ~bits[dcf_pkg::SEC_MPAR];

    n_sec = 59;
    if (flaw == FLAW_LONG) n_sec = 59 + $urandom_range(1, 12);
    else if (flaw == FLAW_SHORT) n_sec = $urandom_range(1, 58);
    bad_at = $urandom_range(0, n_sec - 1);

    for (int s = 0; s < n_sec; s++) begin
      width = bits[s] ? pick_in(dcf_pkg::ONE_LO, dcf_pkg::ONE_HI)
                      : pick_in(dcf_pkg::ZERO_LO, dcf_pkg::ZERO_HI);
      gap   = (s == n_sec - 1) ? pick_in(dcf_pkg::MIN_LO, dcf_pkg::MIN_HI)
                               : pick_in(dcf_pkg::SEC_LO, dcf_pkg::SEC_HI);
      if (s == bad_at && flaw == FLAW_PULSE)
        width = $urandom_range(0, 1) ? $urandom_range(20, 60) : $urandom_range(140, 160);
      if (s == bad_at && flaw == FLAW_GAP) begin
        case ($urandom_range(0, 2))
          0:       gap = $urandom_range(600, dcf_pkg::SEC_LO - 1);
          1:       gap = $urandom_range(dcf_pkg::SEC_HI + 1, 1300);
          default: gap = $urandom_range(3200, 4000);
        endcase
      end
      emit_second(width, gap);
    end
  endtask

  task automatic emit_noise();
    int unsigned n;
    n = $urandom_range(3, 12);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       push_tick(1'($urandom_range(0, 1)), 16'($urandom));
        1:       push_tick(gen_lvl, 16'(gen_t + $urandom_range(dcf_pkg::SILENCE_MS + 1, 3600)));
        default: push_tick(~gen_lvl, 16'(gen_t + $urandom_range(10, 2500)));
      endcase
    end
  endtask

  task automatic build_directed();
    push_tick(1'b0, 16'd0);
    push_tick(1'b0, 16'd3000);      // silence just short of the timeout
    push_tick(1'b0, 16'd3001);      // silence timeout
    push_tick(1'b1, 16'd3002);
    push_tick(1'b0, 16'd5000);
    push_tick(1'b1, 16'd5070);      // zero, low edge of window
    push_tick(1'b0, 16'd5900);      // second, low edge
    push_tick(1'b1, 16'd6030);      // zero, high edge
    push_tick(1'b0, 16'd7000);      // second, high edge
    push_tick(1'b1, 16'd7170);      // one, low edge
    push_tick(1'b0, 16'd8900);      // marker, low edge
    push_tick(1'b1, 16'd9130);      // one, high edge
    push_tick(1'b0, 16'd11000);     // marker with no seconds counted
    push_tick(1'b1, 16'd11069);     // just under the zero window
    push_tick(1'b0, 16'd11899);
    push_tick(1'b1, 16'd12030);
    push_tick(1'b0, 16'd13000);
    push_tick(1'b1, 16'd13169);
    push_tick(1'b0, 16'd14899);
    push_tick(1'b1, 16'd15130);
    push_tick(1'b0, 16'd17000);
    push_tick(1'b0, 16'd65535);
    push_tick(1'b1, 16'd64);        // time base wrapped
    push_tick(1'b1, 16'd3065);
  endtask

  task automatic build_random();
    int unsigned target;
    target = tick_q.size() + RANDOM_TICKS;
    emit_marker();
    while (tick_q.size() < target) begin
      if ($urandom_range(0, 99) < 85) begin
        emit_frame();
      end else begin
        emit_noise();
        emit_marker();
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    dcf_pkg::out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_tick(in_item, res);
        decoded_q.push_back(res);
        n_taken++;
        tx_idle = ((n_taken % 300) < 60) ? 0 : idle_len();
      end
      if (!in_valid || !in_stall) begin
        if (tx_idle > 0 || tick_q.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_idle > 0) tx_idle--;
        end else begin
          in_valid <= 1'b1;
          in_item  <= tick_q.pop_front();
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_decoded(out_item);
      // long hold-off so the event queue fills and the input stalls
      if (rx_hold == 0 && long_holds < 2 && beat_cnt >= 400 + 700 * long_holds) begin
        rx_hold = LONG_HOLD;
        long_holds++;
      end else if (rx_hold == 0 && (cycle_cnt % 512) >= 128) begin
        rx_hold = idle_len();
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("dcf77_pulse_and_frame_decoder verification failed");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    n_total = tick_q.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (n_taken < n_total) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("dcf77_pulse_and_frame_decoder verification clean");
    end else begin
      $display("dcf77_pulse_and_frame_decoder verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/dcf_pkg.sv
src/dcf_front.sv
src/dcf_evq.sv
src/dcf_back.sv
src/dcf77_pulse_and_frame_decoder.sv
dv/tb_dcf77_pulse_and_frame_decoder.sv
